>>> rtl/hmi_ufp_pkg.sv
// ----------------------------------------------------------------------------
// hmi_ufp_pkg
// Shared types and constants for the HMI UART frame parser.
// ----------------------------------------------------------------------------
package hmi_ufp_pkg;

  // Default receive buffer depth in bytes.
  localparam int unsigned RxDepthDefault = 64;

  // Field widths of the stream payloads.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 16;
  localparam int unsigned DlenW  = 6;
  localparam int unsigned FlenW  = 7;

  // Output tdata: event_id, event_value, data_length, frame_length, padded to bytes.
  localparam int unsigned OutFieldsW = ByteW + ValueW + DlenW + FlenW;
  localparam int unsigned OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

  // Configuration port.
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_FRAME_HEAD = 2'd0,
    CFG_FRAME_TAIL = 2'd1,
    CFG_SKIP_HEAD  = 2'd2
  } cfg_reg_e;

  // Register reset values.
  localparam logic [ByteW-1:0] FrameHeadReset = 8'hA5;
  localparam logic [ByteW-1:0] FrameTailReset = 8'h5A;
  localparam logic [ByteW-1:0] SkipHeadReset  = 8'h65;

  // Fixed byte codes.
  localparam logic [ByteW-1:0] FillByte   = 8'hFF;
  localparam logic [ByteW-1:0] DigitZero  = 8'h30;
  localparam logic [ByteW-1:0] DigitNine  = 8'h39;

  // Parser modes.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_DATA = 2'd1,
    MODE_SKIP = 2'd2
  } parse_mode_e;

  // Event kinds.
  typedef enum logic {
    EVT_BUTTON = 1'b0,
    EVT_DATA   = 1'b1
  } evt_kind_e;

  // One parsed event.
  typedef struct packed {
    evt_kind_e               kind;
    logic [ByteW-1:0]        id;
    logic [ValueW-1:0]       value;
    logic [DlenW-1:0]        dlen;
    logic [FlenW-1:0]        flen;
  } evt_t;

endpackage

>>> rtl/hmi_ufp_core.sv
// ----------------------------------------------------------------------------
// hmi_ufp_core
// Input byte register, configuration registers and the parser state machine.
// ----------------------------------------------------------------------------
module hmi_ufp_core #(
  parameter int unsigned RX_DEPTH = hmi_ufp_pkg::RxDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration writes.
  input  logic                              cfg_we_i,
  input  logic [hmi_ufp_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [hmi_ufp_pkg::CfgDataW-1:0]  cfg_data_i,
  // Received bytes.
  input  logic                              rx_valid_i,
  output logic                              rx_ready_o,
  input  logic [hmi_ufp_pkg::ByteW-1:0]     rx_byte_i,
  // Parsed events.
  output logic                              evt_valid_o,
  input  logic                              evt_ready_i,
  output hmi_ufp_pkg::evt_t                 evt_o
);
  import hmi_ufp_pkg::*;

  localparam int unsigned PosW = $clog2(RX_DEPTH);
  localparam int unsigned LenW = PosW + 1;

  localparam logic [PosW-1:0] PosLast = PosW'(RX_DEPTH - 1);
  localparam logic [PosW-1:0] PosOne  = PosW'(1);
  localparam logic [PosW-1:0] PosTwo  = PosW'(2);
  localparam logic [LenW-1:0] LenHdr  = LenW'(3);

  // Configuration registers.
  logic [ByteW-1:0] head_q, tail_q, skip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= FrameHeadReset;
      tail_q <= FrameTailReset;
      skip_q <= SkipHeadReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_FRAME_HEAD: head_q <= cfg_data_i;
        CFG_FRAME_TAIL: tail_q <= cfg_data_i;
        CFG_SKIP_HEAD:  skip_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: a byte waits here until the event stage has room.
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             fire;

  assign fire       = in_valid_q && evt_ready_i;
  assign rx_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_ready_o && rx_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Parser state.
  parse_mode_e       mode_q, mode_d;
  logic [1:0]        ff_cnt_q, ff_cnt_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [ByteW-1:0]  id_q, id_d;
  logic [ValueW-1:0] acc_q, acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      ff_cnt_q <= 2'd0;
      pos_q    <= '0;
      acc_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      ff_cnt_q <= ff_cnt_d;
      pos_q    <= pos_d;
      acc_q    <= acc_d;
    end
  end

  // The control id has no reset; it is always written before a tail reads it.
  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  // Helper values for the current byte.
  logic [ByteW-1:0]  b;
  logic              is_digit;
  logic [ValueW-1:0] acc_next;
  logic [LenW-1:0]   len;
  logic              has_data;

  assign b        = in_byte_q;
  assign is_digit = (b >= DigitZero) && (b <= DigitNine);
  // Multiply by ten as two shifts, then add the digit, all modulo 2^16.
  assign acc_next = (acc_q << 3) + (acc_q << 1) + ValueW'(b - DigitZero);
  assign len      = LenW'(pos_q) + LenW'(1);
  assign has_data = len > LenHdr;

  // Next state and event formation.
  always_comb begin
    mode_d      = mode_q;
    ff_cnt_d    = ff_cnt_q;
    pos_d       = pos_q;
    id_d        = id_q;
    acc_d       = acc_q;
    evt_valid_o = 1'b0;
    evt_o.kind  = has_data ? EVT_DATA : EVT_BUTTON;
    evt_o.id    = id_q;
    evt_o.value = has_data ? acc_q : '0;
    evt_o.dlen  = has_data ? DlenW'(len - LenHdr) : '0;
    evt_o.flen  = FlenW'(len);

    if (fire) begin
      case (mode_q)
        MODE_IDLE: begin
          if (b == skip_q) begin
            mode_d   = MODE_SKIP;
            ff_cnt_d = 2'd0;
          end else if (b == FillByte) begin
            // Fill bytes are dropped outside a skipped packet.
          end else if (b == head_q) begin
            mode_d = MODE_DATA;
            pos_d  = PosOne;
            acc_d  = '0;
          end
        end
        MODE_SKIP: begin
          // Leave skip mode after three fill bytes in a row.
          if (b == FillByte) begin
            if (ff_cnt_q == 2'd2) begin
              mode_d   = MODE_IDLE;
              ff_cnt_d = 2'd0;
            end else begin
              ff_cnt_d = ff_cnt_q + 2'd1;
            end
          end else begin
            ff_cnt_d = 2'd0;
          end
        end
        MODE_DATA: begin
          if (b == FillByte) begin
            // Ignored inside a frame as well.
          end else if (b == head_q) begin
            // A new head restarts the frame.
            pos_d = PosOne;
            acc_d = '0;
          end else if (b == tail_q) begin
            evt_valid_o = (pos_q >= PosTwo);
            mode_d      = MODE_IDLE;
            pos_d       = '0;
          end else if (pos_q < PosLast) begin
            if (pos_q == PosOne) begin
              id_d = b;
            end else if (is_digit) begin
              acc_d = acc_next;
            end
            pos_d = pos_q + PosOne;
          end else begin
            // Buffer full: the frame is dropped.
            mode_d = MODE_IDLE;
            pos_d  = '0;
          end
        end
        default: begin
          mode_d = MODE_IDLE;
          pos_d  = '0;
        end
      endcase
    end
  end

endmodule

>>> rtl/hmi_ufp_out_reg.sv
// ----------------------------------------------------------------------------
// hmi_ufp_out_reg
// Output register that holds one event until the downstream side takes it.
// ----------------------------------------------------------------------------
module hmi_ufp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              evt_valid_i,
  output logic              evt_ready_o,
  input  hmi_ufp_pkg::evt_t evt_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hmi_ufp_pkg::evt_t out_evt_o
);
  import hmi_ufp_pkg::*;

  logic valid_q;
  evt_t evt_q;

  // Room for a new event when empty or when the held one leaves now.
  assign evt_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_evt_o   = evt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (evt_ready_o) begin
      valid_q <= evt_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_ready_o && evt_valid_i) begin
      evt_q <= evt_i;
    end
  end

endmodule

>>> rtl/hmi_uart_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// hmi_uart_frame_parser_unit
// Byte-serial parser for HMI panel frames with a stream interface.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle while the event side keeps up; a held
// event stalls the byte side once the input register is also occupied.
// An event word is offered on the master side once its tail byte has passed the
// input register and the event has been captured in the output register.
// Reset clears the parser to idle, empties both registers and restores the
// head, tail and skip byte registers to their defaults.
module hmi_uart_frame_parser_unit #(
  parameter int unsigned RX_DEPTH = hmi_ufp_pkg::RxDepthDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [hmi_ufp_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [hmi_ufp_pkg::CfgDataW-1:0]     cfg_data_i,
  // Received bytes.
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [7:0] rx_byte
  input  logic [hmi_ufp_pkg::ByteW-1:0]        s_axis_tdata_i,
  // Events.
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [7:0] event_id, [23:8] event_value, [29:24] data_length,
  // [36:30] frame_length, [39:37] zero
  output logic [hmi_ufp_pkg::OutTdataW-1:0]    m_axis_tdata_o,
  // [0] event_kind
  output logic                                 m_axis_tuser_o
);
  import hmi_ufp_pkg::*;

  logic evt_valid, evt_ready;
  evt_t evt, out_evt;

  hmi_ufp_core #(
    .RX_DEPTH (RX_DEPTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .rx_valid_i  (s_axis_tvalid_i),
    .rx_ready_o  (s_axis_tready_o),
    .rx_byte_i   (s_axis_tdata_i),
    .evt_valid_o (evt_valid),
    .evt_ready_i (evt_ready),
    .evt_o       (evt)
  );

  hmi_ufp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_valid),
    .evt_ready_o (evt_ready),
    .evt_i       (evt),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_evt_o   (out_evt)
  );

  // Pack the event fields, lowest field first, zero padded to whole bytes.
  assign m_axis_tdata_o = OutTdataW'({out_evt.flen, out_evt.dlen, out_evt.value, out_evt.id});
  assign m_axis_tuser_o = out_evt.kind;

endmodule
